FILE: hw/rtl/trlr_pkg.sv
// ----------------------------------------------------------------------------
// trlr_pkg: shared types and constants for the TFRC receiver
// Command codes, status bundle, datapath widths and the loss interval weights.
// ----------------------------------------------------------------------------
package trlr_pkg;

  localparam int DIV_W  = 48;
  localparam int WGT_W  = 5;
  localparam int PROD_W = 32 + WGT_W;
  localparam int SUM_W  = 44;
  localparam int IV_W   = 46;
  localparam int PW_W   = 8;
  localparam int RATE_W = 20;
  localparam int RECV_W = 48;
  localparam logic [RATE_W-1:0] RATE_MAX = '1;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PREP,
    CMD_DIV_DT,
    CMD_SPLIT,
    CMD_WALK_A,
    CMD_WALK_B,
    CMD_WALK_END,
    CMD_PR_INIT,
    CMD_PR_MUL,
    CMD_PR_ACC,
    CMD_RATE_A,
    CMD_RATE_B,
    CMD_RATE_C,
    CMD_RATE_D,
    CMD_RATE_END,
    CMD_FB_A,
    CMD_FB_RECV,
    CMD_OUT_FB,
    CMD_OUT_FIRST
  } cmd_t;

  typedef struct packed {
    logic op;
    logic started;
    logic walk_zero;
    logic walk_last;
    logic fresh;
    logic pr_skip;
    logic pr_last;
    logic rose;
    logic ack_empty;
    logic need_rate;
    logic div_busy;
    logic out_free;
  } stat_t;

  // Loss interval weight of interval i for a history of k events.
  function automatic logic [WGT_W-1:0] weight(input int i, input int k);
    int raw;
    raw = (2 * i < k) ? (k + 2) : (2 * (k - i));
    if ((k & 1) == 0) begin
      raw = raw >> 1;
    end
    return WGT_W'(raw);
  endfunction

endpackage

FILE: hw/rtl/trlr_pkt_if.sv
// ----------------------------------------------------------------------------
// trlr_pkt_if: input item channel
// Valid/ready channel carrying packet arrivals and timer expiries.
// ----------------------------------------------------------------------------
interface trlr_pkt_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] seq;
  logic [31:0] now_time;
  logic [31:0] tx_stamp;
  logic [23:0] rtt_us;
  logic [15:0] payload_bytes;

  modport source (output valid, op, seq, now_time, tx_stamp, rtt_us, payload_bytes,
                  input ready);
  modport sink (input valid, op, seq, now_time, tx_stamp, rtt_us, payload_bytes,
                output ready);
endinterface

FILE: hw/rtl/trlr_fbk_if.sv
// ----------------------------------------------------------------------------
// trlr_fbk_if: feedback report channel
// Valid/ready channel carrying one receiver feedback report per transfer.
// ----------------------------------------------------------------------------
interface trlr_fbk_if #(parameter int BITMAP_SPAN = 64);
  logic                   valid;
  logic                   ready;
  logic [31:0]            echo_stamp;
  logic [31:0]            hold_delay;
  logic [47:0]            recv_rate;
  logic [19:0]            loss_rate;
  logic [BITMAP_SPAN-1:0] ack_bits;
  logic [31:0]            ack_base;
  logic [BITMAP_SPAN-1:0] loss_bits;
  logic [31:0]            loss_base;
  logic                   range_error;

  modport source (output valid, echo_stamp, hold_delay, recv_rate, loss_rate, ack_bits,
                  ack_base, loss_bits, loss_base, range_error, input ready);
  modport sink (input valid, echo_stamp, hold_delay, recv_rate, loss_rate, ack_bits,
                ack_base, loss_bits, loss_base, range_error, output ready);
endinterface

FILE: hw/rtl/trlr_div.sv
// ----------------------------------------------------------------------------
// trlr_div: serial restoring divider
// One quotient bit per cycle; busy while bits remain.
// ----------------------------------------------------------------------------
module trlr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [trlr_pkg::DIV_W-1:0] dividend,
  input  logic [trlr_pkg::DIV_W-1:0] divisor,
  output logic                       busy,
  output logic [trlr_pkg::DIV_W-1:0] quotient,
  output logic [trlr_pkg::DIV_W-1:0] remainder
);
  localparam int W  = trlr_pkg::DIV_W;
  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] cnt;
  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [W:0]    sh;
  logic [W+1:0]  diff;

  assign sh   = {rem, quo[W-1]};
  assign diff = {1'b0, sh} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (cnt != '0) begin
      if (!diff[W+1]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign busy      = (cnt != '0);
  assign quotient  = quo;
  assign remainder = rem;
endmodule

FILE: hw/rtl/trlr_dp.sv
// ----------------------------------------------------------------------------
// trlr_dp: receiver datapath
// Item registers, bitmaps, loss event ring, interval sums, rate and report.
// ----------------------------------------------------------------------------
module trlr_dp #(
  parameter int LOSS_EVENTS = 8,
  parameter int BITMAP_SPAN = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  trlr_pkg::cmd_t         cmd,
  output trlr_pkg::stat_t        stat,
  input  logic                   in_op,
  input  logic [31:0]            in_seq,
  input  logic [31:0]            in_now,
  input  logic [31:0]            in_tx,
  input  logic [23:0]            in_rtt,
  input  logic [15:0]            in_pay,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [31:0]            echo_stamp,
  output logic [31:0]            hold_delay,
  output logic [47:0]            recv_rate,
  output logic [19:0]            loss_rate,
  output logic [BITMAP_SPAN-1:0] ack_bits,
  output logic [31:0]            ack_base,
  output logic [BITMAP_SPAN-1:0] loss_bits,
  output logic [31:0]            loss_base,
  output logic                   range_error
);
  localparam int HW = $clog2(LOSS_EVENTS);
  localparam int CW = $clog2(LOSS_EVENTS + 1);
  localparam int IW = $clog2(BITMAP_SPAN);
  localparam int KW = $clog2(BITMAP_SPAN + 1);
  localparam int DW = trlr_pkg::DIV_W;
  localparam logic [trlr_pkg::WGT_W-1:0] W0 = trlr_pkg::weight(0, LOSS_EVENTS);
  localparam logic [HW-1:0] HEAD_LAST = HW'(LOSS_EVENTS - 1);

  // item registers
  logic        item_op;
  logic [31:0] item_seq, item_now, item_tx;
  logic [23:0] item_rtt;
  logic [15:0] item_pay;

  // receiver state
  logic                   started;
  logic [31:0]            last_seq, last_time, last_arrival, last_tx, byte_count, fb_time;
  logic [BITMAP_SPAN-1:0] ack_store, loss_store;
  logic [31:0]            ack_first, loss_first;
  logic                   overflow;
  logic [HW-1:0]          head;
  logic [CW-1:0]          count;
  logic [31:0]            head_seq, head_time;
  logic [trlr_pkg::SUM_W-1:0] ps_now, ps_old;
  logic [trlr_pkg::PW_W-1:0]  pw;
  logic [31:0]            rate_calc_seq;
  logic [trlr_pkg::RATE_W-1:0] cur_rate;
  logic                   fresh;
  logic [31:0]            ev_seq [LOSS_EVENTS];

  // working registers
  logic [31:0]   gap, dt, qd, rd, acc_r, acc_t;
  logic [KW-1:0] walk, k;
  logic [CW-1:0] pr_i;
  logic [HW-1:0] rd_idx;
  logic [31:0]   mem_q, prev_seq, rdiff;
  logic [trlr_pkg::PROD_W-1:0] p_now, p_old, rprod;
  logic [trlr_pkg::IV_W-1:0]   iv0;
  logic          iv_zero;
  logic [31:0]   elapsed;

  // divider
  logic          div_start, div_busy;
  logic [DW-1:0] div_dvd, div_dvs, div_quo, div_rem;

  // combinational helpers
  logic [32:0]   bc_sum;
  logic [31:0]   bc_add;
  logic [31:0]   ack_off, loss_off, walk_s, tdiff, miss, r_sum, ivp, gap_c;
  logic          ack_hit, loss_hit, gap_ok, carry, ev_we;
  logic [32:0]   r_sub;
  logic [HW-1:0] head_inc, rd_dec, widx;
  logic [trlr_pkg::IV_W-1:0] ivmax;
  logic [trlr_pkg::PW_W:0]   wsum;
  logic [trlr_pkg::RATE_W-1:0] rate_new;
  logic          out_free, out_load_fb, out_load_first;
  logic [trlr_pkg::WGT_W-1:0] w_i, w_im1;

  assign bc_sum   = {1'b0, byte_count} + 33'(item_pay);
  assign bc_add   = bc_sum[32] ? '1 : bc_sum[31:0];
  assign ack_off  = item_seq - ack_first;
  assign ack_hit  = ack_off < 32'(BITMAP_SPAN);
  assign walk_s   = last_seq + 32'(k);
  assign loss_off = walk_s - loss_first;
  assign loss_hit = loss_off < 32'(BITMAP_SPAN);
  assign tdiff    = acc_t - head_time;
  assign gap_c    = item_seq - last_seq;
  assign gap_ok   = (gap_c >= 32'd2) && !gap_c[31];
  assign miss     = gap_c - 32'd1;
  assign r_sum    = acc_r + rd;
  assign r_sub    = {1'b0, r_sum} - {1'b0, gap};
  assign carry    = !r_sub[32];
  assign head_inc = (head == HEAD_LAST) ? '0 : head + 1'b1;
  assign rd_dec   = (rd_idx == '0) ? HEAD_LAST : rd_idx - 1'b1;
  assign widx     = (count == '0) ? head : head_inc;
  assign ev_we    = (cmd == trlr_pkg::CMD_WALK_B) &&
                    ((count == '0) || (tdiff > {8'd0, item_rtt}));
  assign ivp      = prev_seq - mem_q;
  assign ivmax    = (iv0 > trlr_pkg::IV_W'(ps_old)) ? iv0 : trlr_pkg::IV_W'(ps_old);
  assign wsum     = (trlr_pkg::PW_W + 1)'(W0) + (trlr_pkg::PW_W + 1)'(pw);
  assign rate_new = iv_zero ? trlr_pkg::RATE_MAX :
                    (div_quo > DW'(trlr_pkg::RATE_MAX)) ? trlr_pkg::RATE_MAX :
                    div_quo[trlr_pkg::RATE_W-1:0];
  assign out_free       = !out_valid || out_ready;
  assign out_load_fb    = (cmd == trlr_pkg::CMD_OUT_FB) && out_free;
  assign out_load_first = (cmd == trlr_pkg::CMD_OUT_FIRST) && out_free;
  assign w_i      = trlr_pkg::weight(int'(pr_i), LOSS_EVENTS);
  assign w_im1    = trlr_pkg::weight(int'(pr_i) - 1, LOSS_EVENTS);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (cmd)
      trlr_pkg::CMD_DIV_DT: begin
        div_start = 1'b1;
        div_dvd   = DW'(dt);
        div_dvs   = DW'(gap);
      end
      trlr_pkg::CMD_RATE_D: begin
        div_start = 1'b1;
        div_dvd   = DW'({wsum, 16'd0});
        div_dvs   = DW'(ivmax);
      end
      trlr_pkg::CMD_FB_RECV: begin
        div_start = 1'b1;
        div_dvd   = DW'({byte_count, 16'd0});
        div_dvs   = DW'(elapsed);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  trlr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // event ring
  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_seq[widx] <= walk_s;
    end
    mem_q <= ev_seq[rd_idx];
  end

  // receiver state
  always_ff @(posedge clk) begin
    if (rst) begin
      started       <= 1'b0;
      last_seq      <= '0;
      last_time     <= '0;
      last_arrival  <= '0;
      last_tx       <= '0;
      byte_count    <= '0;
      fb_time       <= '0;
      ack_store     <= '0;
      ack_first     <= '0;
      loss_store    <= '0;
      loss_first    <= '0;
      overflow      <= 1'b0;
      head          <= '0;
      count         <= '0;
      ps_now        <= '0;
      ps_old        <= '0;
      pw            <= '0;
      rate_calc_seq <= '0;
      cur_rate      <= '0;
      fresh         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load_fb || out_load_first) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        trlr_pkg::CMD_PREP: begin
          last_tx      <= item_tx;
          last_arrival <= item_now;
          byte_count   <= bc_add;
          fresh        <= 1'b0;
          if (ack_store == '0) begin
            ack_first <= item_seq;
            ack_store <= BITMAP_SPAN'(1);
          end else if (ack_hit) begin
            ack_store <= ack_store | (BITMAP_SPAN'(1) << ack_off[IW-1:0]);
          end
          if (((ack_store != '0) && !ack_hit) || (gap_ok && miss > 32'(BITMAP_SPAN))) begin
            overflow <= 1'b1;
          end
        end
        trlr_pkg::CMD_WALK_B: begin
          if (loss_store == '0) begin
            loss_first <= walk_s;
            loss_store <= BITMAP_SPAN'(1);
          end else if (loss_hit) begin
            loss_store <= loss_store | (BITMAP_SPAN'(1) << loss_off[IW-1:0]);
          end else begin
            overflow <= 1'b1;
          end
          if (ev_we) begin
            fresh <= 1'b1;
            if (count == '0) begin
              count <= CW'(1);
            end else begin
              head <= head_inc;
              if (count < CW'(LOSS_EVENTS)) begin
                count <= count + 1'b1;
              end
            end
          end
        end
        trlr_pkg::CMD_WALK_END: begin
          last_seq  <= item_seq;
          last_time <= item_now;
          if (fresh) begin
            rate_calc_seq <= item_seq;
          end
        end
        trlr_pkg::CMD_PR_INIT: begin
          ps_now <= '0;
          ps_old <= '0;
          pw     <= '0;
        end
        trlr_pkg::CMD_PR_ACC: begin
          ps_now <= ps_now + trlr_pkg::SUM_W'(p_now);
          ps_old <= ps_old + trlr_pkg::SUM_W'(p_old);
          pw     <= pw + trlr_pkg::PW_W'(w_i);
        end
        trlr_pkg::CMD_RATE_END: begin
          cur_rate <= rate_new;
        end
        trlr_pkg::CMD_FB_A: begin
          fb_time <= item_now;
        end
        trlr_pkg::CMD_OUT_FB: begin
          if (out_free) begin
            byte_count <= '0;
            ack_store  <= '0;
            ack_first  <= '0;
            loss_store <= '0;
            loss_first <= '0;
            overflow   <= 1'b0;
          end
        end
        trlr_pkg::CMD_OUT_FIRST: begin
          if (out_free) begin
            started    <= 1'b1;
            last_seq   <= item_seq;
            last_time  <= item_now;
            byte_count <= bc_add;
          end
        end
        default: begin
          started <= started;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd)
      trlr_pkg::CMD_LOAD: begin
        item_op  <= in_op;
        item_seq <= in_seq;
        item_now <= in_now;
        item_tx  <= in_tx;
        item_rtt <= in_rtt;
        item_pay <= in_pay;
      end
      trlr_pkg::CMD_PREP: begin
        gap <= gap_c;
        dt  <= item_now - last_time;
        k   <= '0;
        if (!gap_ok) begin
          walk <= '0;
        end else if (miss > 32'(BITMAP_SPAN)) begin
          walk <= KW'(BITMAP_SPAN);
        end else begin
          walk <= miss[KW-1:0];
        end
      end
      trlr_pkg::CMD_SPLIT: begin
        qd    <= div_quo[31:0];
        rd    <= div_rem[31:0];
        acc_r <= '0;
        acc_t <= last_time;
      end
      trlr_pkg::CMD_WALK_A: begin
        acc_r <= carry ? r_sub[31:0] : r_sum;
        acc_t <= acc_t + qd + 32'(carry);
        k     <= k + 1'b1;
      end
      trlr_pkg::CMD_WALK_B: begin
        if (ev_we) begin
          head_seq  <= walk_s;
          head_time <= acc_t;
        end
      end
      trlr_pkg::CMD_PR_INIT: begin
        pr_i     <= CW'(1);
        rd_idx   <= (head == '0) ? HEAD_LAST : head - 1'b1;
        prev_seq <= head_seq;
      end
      trlr_pkg::CMD_PR_MUL: begin
        p_now <= trlr_pkg::PROD_W'(ivp) * trlr_pkg::PROD_W'(w_i);
        p_old <= trlr_pkg::PROD_W'(ivp) * trlr_pkg::PROD_W'(w_im1);
      end
      trlr_pkg::CMD_PR_ACC: begin
        prev_seq <= mem_q;
        pr_i     <= pr_i + 1'b1;
        rd_idx   <= rd_dec;
      end
      trlr_pkg::CMD_RATE_A: begin
        rdiff <= last_seq - head_seq + 32'd1;
      end
      trlr_pkg::CMD_RATE_B: begin
        rprod <= trlr_pkg::PROD_W'(rdiff) * trlr_pkg::PROD_W'(W0);
      end
      trlr_pkg::CMD_RATE_C: begin
        iv0 <= trlr_pkg::IV_W'(rprod) + trlr_pkg::IV_W'(ps_now);
      end
      trlr_pkg::CMD_RATE_D: begin
        iv_zero <= (ivmax == '0);
      end
      trlr_pkg::CMD_FB_A: begin
        elapsed <= item_now - fb_time;
      end
      default: begin
        k <= k;
      end
    endcase
  end

  // report register
  always_ff @(posedge clk) begin
    if (out_load_first) begin
      echo_stamp  <= item_tx;
      hold_delay  <= '0;
      recv_rate   <= '0;
      loss_rate   <= cur_rate;
      ack_bits    <= BITMAP_SPAN'(1);
      ack_base    <= item_seq;
      loss_bits   <= '0;
      loss_base   <= '0;
      range_error <= 1'b0;
    end else if (out_load_fb) begin
      echo_stamp  <= last_tx;
      hold_delay  <= item_now - last_arrival;
      if (elapsed == '0) begin
        recv_rate <= (byte_count != '0) ? '1 : '0;
      end else begin
        recv_rate <= div_quo[trlr_pkg::RECV_W-1:0];
      end
      loss_rate   <= cur_rate;
      ack_bits    <= ack_store;
      ack_base    <= ack_first;
      loss_bits   <= loss_store;
      loss_base   <= (loss_store != '0) ? loss_first : '0;
      range_error <= overflow;
    end
  end

  always_comb begin
    stat           = '0;
    stat.op        = item_op;
    stat.started   = started;
    stat.walk_zero = (walk == '0);
    stat.walk_last = (k == walk);
    stat.fresh     = fresh;
    stat.pr_skip   = (count <= CW'(1));
    stat.pr_last   = ((CW + 1)'(pr_i) + 1'b1 == (CW + 1)'(count));
    stat.rose      = (rate_new > cur_rate);
    stat.ack_empty = (ack_store == '0);
    stat.need_rate = (last_seq != rate_calc_seq) && (count != '0);
    stat.div_busy  = div_busy;
    stat.out_free  = out_free;
  end
endmodule

FILE: hw/rtl/trlr_ctrl.sv
// ----------------------------------------------------------------------------
// trlr_ctrl: receiver sequencer
// Steps the datapath through gap walk, interval sums, rate and report.
// ----------------------------------------------------------------------------
module trlr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            ready,
  input  trlr_pkg::stat_t stat,
  output trlr_pkg::cmd_t  cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_PREP, S_DT_GO, S_DT_WAIT, S_SPLIT, S_WALK_A, S_WALK_B,
    S_WALK_END, S_PR_INIT, S_PR_WAIT, S_PR_MUL, S_PR_ACC, S_RATE_A, S_RATE_B,
    S_RATE_C, S_RATE_D, S_RATE_WAIT, S_RATE_END, S_FB_A, S_FB_RECV, S_FB_WAIT,
    S_FB_OUT, S_FIRST_OUT
  } state_t;

  state_t state;
  logic   rate_fb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rate_fb <= 1'b0;
    end else begin
      case (state)
        S_IDLE:      if (in_valid) state <= S_DISPATCH;
        S_DISPATCH: begin
          if (stat.op) state <= S_FB_A;
          else if (!stat.started) state <= S_FIRST_OUT;
          else state <= S_PREP;
        end
        S_PREP:      state <= S_DT_GO;
        S_DT_GO:     state <= stat.walk_zero ? S_WALK_END : S_DT_WAIT;
        S_DT_WAIT:   if (!stat.div_busy) state <= S_SPLIT;
        S_SPLIT:     state <= S_WALK_A;
        S_WALK_A:    state <= S_WALK_B;
        S_WALK_B:    state <= stat.walk_last ? S_WALK_END : S_WALK_A;
        S_WALK_END:  state <= stat.fresh ? S_PR_INIT : S_IDLE;
        S_PR_INIT: begin
          rate_fb <= 1'b0;
          state   <= stat.pr_skip ? S_RATE_A : S_PR_WAIT;
        end
        S_PR_WAIT:   state <= S_PR_MUL;
        S_PR_MUL:    state <= S_PR_ACC;
        S_PR_ACC:    state <= stat.pr_last ? S_RATE_A : S_PR_WAIT;
        S_RATE_A:    state <= S_RATE_B;
        S_RATE_B:    state <= S_RATE_C;
        S_RATE_C:    state <= S_RATE_D;
        S_RATE_D:    state <= S_RATE_WAIT;
        S_RATE_WAIT: if (!stat.div_busy) state <= S_RATE_END;
        S_RATE_END: begin
          if (rate_fb) state <= S_FB_RECV;
          else if (stat.rose) state <= S_FB_A;
          else state <= S_IDLE;
        end
        S_FB_A: begin
          if (stat.ack_empty) begin
            state <= S_IDLE;
          end else if (stat.need_rate) begin
            rate_fb <= 1'b1;
            state   <= S_RATE_A;
          end else begin
            state <= S_FB_RECV;
          end
        end
        S_FB_RECV:   state <= S_FB_WAIT;
        S_FB_WAIT:   if (!stat.div_busy) state <= S_FB_OUT;
        S_FB_OUT:    if (stat.out_free) state <= S_IDLE;
        S_FIRST_OUT: if (stat.out_free) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

  assign ready = (state == S_IDLE);

  always_comb begin
    case (state)
      S_IDLE:      cmd = in_valid ? trlr_pkg::CMD_LOAD : trlr_pkg::CMD_NONE;
      S_PREP:      cmd = trlr_pkg::CMD_PREP;
      S_DT_GO:     cmd = trlr_pkg::CMD_DIV_DT;
      S_SPLIT:     cmd = trlr_pkg::CMD_SPLIT;
      S_WALK_A:    cmd = trlr_pkg::CMD_WALK_A;
      S_WALK_B:    cmd = trlr_pkg::CMD_WALK_B;
      S_WALK_END:  cmd = trlr_pkg::CMD_WALK_END;
      S_PR_INIT:   cmd = trlr_pkg::CMD_PR_INIT;
      S_PR_MUL:    cmd = trlr_pkg::CMD_PR_MUL;
      S_PR_ACC:    cmd = trlr_pkg::CMD_PR_ACC;
      S_RATE_A:    cmd = trlr_pkg::CMD_RATE_A;
      S_RATE_B:    cmd = trlr_pkg::CMD_RATE_B;
      S_RATE_C:    cmd = trlr_pkg::CMD_RATE_C;
      S_RATE_D:    cmd = trlr_pkg::CMD_RATE_D;
      S_RATE_END:  cmd = trlr_pkg::CMD_RATE_END;
      S_FB_A:      cmd = trlr_pkg::CMD_FB_A;
      S_FB_RECV:   cmd = trlr_pkg::CMD_FB_RECV;
      S_FB_OUT:    cmd = trlr_pkg::CMD_OUT_FB;
      S_FIRST_OUT: cmd = trlr_pkg::CMD_OUT_FIRST;
      default:     cmd = trlr_pkg::CMD_NONE;
    endcase
  end
endmodule

FILE: hw/rtl/tfrc_receiver_loss_rate.sv
// ----------------------------------------------------------------------------
// tfrc_receiver_loss_rate: TFRC receiver with loss event rate
// Counts bytes, keeps ack and loss bitmaps, tracks loss events and reports.
//
//   channel  dir  carries
//   pkt      in   packet arrival (op 0) or feedback timer expiry (op 1)
//   fbk      out  feedback report, at most one per input transfer
//
// A packet without loss does not wait on the divider. A gap adds a divide
// and a walk step per missing number; a new loss event adds a pass over the
// stored intervals and a rate step with a divide; a report adds a divide, and
// a timer that needs a fresh rate adds the rate step too. Reset clears the
// receiver state and the report valid flag, but not the working or report
// data registers. A stalled report holds the block only when the next report is ready.
// ----------------------------------------------------------------------------
module tfrc_receiver_loss_rate #(
  parameter int LOSS_EVENTS = 8,
  parameter int BITMAP_SPAN = 64
) (
  input logic        clk,
  input logic        rst,
  trlr_pkt_if.sink   pkt,
  trlr_fbk_if.source fbk
);
  trlr_pkg::cmd_t  cmd;
  trlr_pkg::stat_t stat;

  trlr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pkt.valid),
    .ready    (pkt.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trlr_dp #(
    .LOSS_EVENTS (LOSS_EVENTS),
    .BITMAP_SPAN (BITMAP_SPAN)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (pkt.op),
    .in_seq      (pkt.seq),
    .in_now      (pkt.now_time),
    .in_tx       (pkt.tx_stamp),
    .in_rtt      (pkt.rtt_us),
    .in_pay      (pkt.payload_bytes),
    .out_ready   (fbk.ready),
    .out_valid   (fbk.valid),
    .echo_stamp  (fbk.echo_stamp),
    .hold_delay  (fbk.hold_delay),
    .recv_rate   (fbk.recv_rate),
    .loss_rate   (fbk.loss_rate),
    .ack_bits    (fbk.ack_bits),
    .ack_base    (fbk.ack_base),
    .loss_bits   (fbk.loss_bits),
    .loss_base   (fbk.loss_base),
    .range_error (fbk.range_error)
  );
endmodule

FILE: hw/rtl/trlr_chk.sv
// ----------------------------------------------------------------------------
// trlr_chk: port checker for the TFRC receiver
// Handshake and sequencing properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module trlr_chk #(
  parameter int BITMAP_SPAN = 64
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   pkt_valid,
  input logic                   pkt_ready,
  input logic                   fbk_valid,
  input logic                   fbk_ready,
  input logic [BITMAP_SPAN-1:0] ack_bits,
  input logic [31:0]            echo_stamp
);
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    fbk_valid && !fbk_ready |=> fbk_valid)
    else $error("report dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    fbk_valid && !fbk_ready |=> $stable(ack_bits) && $stable(echo_stamp))
    else $error("report changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_ready |=> !pkt_ready)
    else $error("second transfer taken while busy");

  a_report_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(fbk_valid) |-> !$past(pkt_ready))
    else $error("report issued from idle");
endmodule

bind tfrc_receiver_loss_rate trlr_chk #(.BITMAP_SPAN(BITMAP_SPAN)) u_chk (
  .clk        (clk),
  .rst        (rst),
  .pkt_valid  (pkt.valid),
  .pkt_ready  (pkt.ready),
  .fbk_valid  (fbk.valid),
  .fbk_ready  (fbk.ready),
  .ack_bits   (fbk.ack_bits),
  .echo_stamp (fbk.echo_stamp)
);
